// ===== hw/rtl/ldw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldw_pkg
// Shared widths, types and the digit segment table of the LCD digit writer.
// ----------------------------------------------------------------------------
package ldw_pkg;

    localparam int VALUE_W         = 32;
    localparam int DIGITS          = 10;
    localparam int ROWS            = 4;
    localparam int ROW_NIBBLES     = 6;
    localparam int ROW_W           = ROW_NIBBLES * 4;
    localparam int DIGIT_POSITIONS = 6;
    localparam int POS_USED        = (DIGIT_POSITIONS < ROW_NIBBLES) ?
                                     DIGIT_POSITIONS : ROW_NIBBLES;
    localparam int STEPS_PER_STAGE = 8;
    localparam int BCD_STAGES      = VALUE_W / STEPS_PER_STAGE;
    localparam int GLYPH_W         = 16;
    localparam int CNT_W           = 4;

    typedef logic [DIGITS-1:0][3:0]    t_digits;
    typedef logic [ROWS-1:0][ROW_W-1:0] t_rows;

    typedef struct packed {
        logic                neg;
        t_digits             bcd;
        logic [VALUE_W-1:0]  bin;
    } t_conv;

    function automatic logic [GLYPH_W-1:0] f_glyph(input logic [3:0] digit);
        logic [GLYPH_W-1:0] g;
        case (digit)
            4'd0:    g = 16'h1551;
            4'd1:    g = 16'h0110;
            4'd2:    g = 16'h1e11;
            4'd3:    g = 16'h1b11;
            4'd4:    g = 16'h0b50;
            4'd5:    g = 16'h1b41;
            4'd6:    g = 16'h1f41;
            4'd7:    g = 16'h0111;
            4'd8:    g = 16'h1f51;
            4'd9:    g = 16'h0b51;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

// ===== hw/rtl/ldw_value_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldw_value_if
// Valid/ready channel carrying one signed value per transfer.
// ----------------------------------------------------------------------------
interface ldw_value_if import ldw_pkg::*;;

    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);

endinterface

// ===== hw/rtl/ldw_rows_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldw_rows_if
// Valid/ready channel carrying the four segment rows per transfer.
// ----------------------------------------------------------------------------
interface ldw_rows_if import ldw_pkg::*;;

    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   row_zero;
    logic [ROW_W-1:0]   row_one;
    logic [ROW_W-1:0]   row_two;
    logic [ROW_W-1:0]   row_three;

    modport source (output valid, output row_zero, output row_one, output row_two,
                    output row_three, input ready);
    modport sink   (input valid, input row_zero, input row_one, input row_two,
                    input row_three, output ready);

endinterface

// ===== hw/rtl/decimal_lcd_digit_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_lcd_digit_writer
// Convert a signed value to decimal text and write it into segment rows.
// ----------------------------------------------------------------------------
// Usage:
//   i_value carries one signed 32-bit number per transfer. o_rows returns
//   the four 24-bit segment rows after that number has been written, one
//   transfer out for every transfer in, in order.
//   From the input transfer to o_rows.valid a value passes an input
//   register, four registered conversion stages of eight shift-and-add-3
//   steps each, then the row register. Throughput is one value per cycle
//   while o_rows.ready holds; the per-stage valid bits let bubbles close
//   up, so input keeps flowing while a result waits if any stage is empty.
//   When the receiver stalls, the row register holds and the stages fill;
//   i_value.ready drops only once every stage holds an item.
//   Synchronous reset clears all stage valids, the output valid and the
//   segment rows to zero.
// ----------------------------------------------------------------------------
module decimal_lcd_digit_writer import ldw_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ldw_value_if.sink    i_value,
    ldw_rows_if.source   o_rows
);

    t_conv                r_p [0:BCD_STAGES];
    logic [BCD_STAGES:0]  r_v;
    logic                 r_ov;
    t_rows                r_rows;
    t_rows                n_rows;
    t_conv                w_stage [0:BCD_STAGES-1];
    logic [BCD_STAGES+1:0] w_adv;
    logic [VALUE_W-1:0]   w_raw;
    logic                 w_neg;

    assign w_raw = i_value.value;
    assign w_neg = w_raw[VALUE_W-1];

    always_comb begin
        w_adv[BCD_STAGES+1] = !r_ov || o_rows.ready;
        for (int k = BCD_STAGES; k >= 0; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    assign i_value.ready = w_adv[0];

    generate
        for (genvar g = 0; g < BCD_STAGES; g++) begin : g_stage
            ldw_bcd_stage u_stage (
                .i_conv (r_p[g]),
                .o_conv (w_stage[g])
            );
        end
    endgenerate

    ldw_row_update u_update (
        .i_conv (r_p[BCD_STAGES]),
        .i_rows (r_rows),
        .o_rows (n_rows)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv[0] && i_value.valid) begin
            r_p[0].neg <= w_neg;
            r_p[0].bcd <= '0;
            r_p[0].bin <= w_neg ? (VALUE_W'(0) - w_raw) : w_raw;
        end
        for (int k = 1; k <= BCD_STAGES; k++) begin
            if (w_adv[k] && r_v[k-1]) begin
                r_p[k] <= w_stage[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_ov   <= 1'b0;
            r_rows <= '0;
        end else begin
            if (w_adv[0]) begin
                r_v[0] <= i_value.valid;
            end
            for (int k = 1; k <= BCD_STAGES; k++) begin
                if (w_adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (w_adv[BCD_STAGES+1]) begin
                r_ov <= r_v[BCD_STAGES];
                if (r_v[BCD_STAGES]) begin
                    r_rows <= n_rows;
                end
            end
        end
    end

    assign o_rows.valid     = r_ov;
    assign o_rows.row_zero  = r_rows[0];
    assign o_rows.row_one   = r_rows[1];
    assign o_rows.row_two   = r_rows[2];
    assign o_rows.row_three = r_rows[3];

endmodule

// ===== hw/rtl/ldw_bcd_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldw_bcd_stage
// Eight shift-and-add-3 steps of the binary to BCD conversion.
// ----------------------------------------------------------------------------
module ldw_bcd_stage import ldw_pkg::*; (
    input  t_conv i_conv,
    output t_conv o_conv
);

    always_comb begin
        t_conv c;
        c = i_conv;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (c.bcd[d] >= 4'd5) begin
                    c.bcd[d] = c.bcd[d] + 4'd3;
                end
            end
            {c.bcd, c.bin} = {c.bcd, c.bin} << 1;
        end
        o_conv = c;
    end

endmodule

// ===== hw/rtl/ldw_row_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldw_row_update
// Place the leading characters of the decimal text into the segment rows.
// ----------------------------------------------------------------------------
module ldw_row_update import ldw_pkg::*; (
    input  t_conv i_conv,
    input  t_rows i_rows,
    output t_rows o_rows
);

    always_comb begin
        logic [CNT_W-1:0]   nd;
        logic [CNT_W-1:0]   pos;
        logic [CNT_W-1:0]   j;
        logic [CNT_W-1:0]   idx;
        logic [GLYPH_W-1:0] g;
        nd  = CNT_W'(1);
        pos = '0;
        j   = '0;
        idx = '0;
        g   = '0;
        for (int d = 1; d < DIGITS; d++) begin
            if (i_conv.bcd[d] != 4'd0) begin
                nd = CNT_W'(d + 1);
            end
        end
        o_rows = i_rows;
        for (int p = 0; p < POS_USED; p++) begin
            pos = CNT_W'(p);
            j   = pos - CNT_W'(i_conv.neg);
            // minus sign holds its position without writing
            if (!(i_conv.neg && pos == '0) && j < nd) begin
                idx = nd - CNT_W'(1) - j;
                g   = f_glyph(i_conv.bcd[idx]);
                for (int k = 0; k < ROWS; k++) begin
                    o_rows[k][4*p +: 4] = g[4*k +: 4];
                end
            end
        end
    end

endmodule
